// ===== hdl/lslt_pkg.sv =====
`default_nettype none

package lslt_pkg;

  // field widths
  localparam int ADC_W = 14;
  localparam int LUX_W = 17;
  localparam int PCT_W = 8;
  localparam int MAG_W = 14;
  localparam int THR_W = 15;

  // stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_MARGIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_LUX     = 8'd1;

  localparam logic [PCT_W-1:0] NOISE_MARGIN_RST = 8'd20;
  localparam logic [LUX_W-1:0] DARK_LUX_RST     = 17'd50;

  // arithmetic constants
  localparam logic [ADC_W-1:0] MIDPOINT = 14'd8192;
  localparam int               MAG_MAX  = 8192;
  localparam int               PCT_BASE = 100;
  localparam logic [THR_W-1:0] THR_MAX  = 15'd30720;

  // average of rectified samples never exceeds the rectified maximum
  localparam int AVG_W  = 14;
  // avg * (100 + percent), at most 8192 * 355
  localparam int SCALE_W = PCT_W + 1;
  localparam int PROD_W  = AVG_W + SCALE_W;

endpackage

`default_nettype wire

// ===== hdl/loud_sound_light_trigger_unit.sv =====
`default_nettype none

// channel   direction  handshake                      payload
// -------   ---------  -----------------------------  ----------------------------------------
// s_axis    in         s_axis_tvalid / s_axis_tready  adc_sample, ambient_lux
// m_axis    out        m_axis_tvalid / m_axis_tready  loud, light_request, level_threshold
// cfg       in         cfg_valid_i / cfg_ready_o      register index, write data
//
// one transfer per cycle sustained while the output is not stalled
// the running sum loop (subtract oldest, add newest) closes at the input in sum_q
// rst_ni clears the window, running sum and pipeline valids and resets the two registers
// each stage holds while the stage after it is full and stalled; bubbles collapse, so
// the input keeps taking transfers while a finished result waits at the output
module loud_sound_light_trigger_unit
  import lslt_pkg::*;
#(
  parameter int WINDOW_LEN = 20,
  parameter int RUN_LEN    = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // [13:0] adc_sample, [30:14] ambient_lux, [31] zero
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,

  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [0] loud, [1] light_request, [16:2] level_threshold, [23:17] zero
  output      logic [M_TDATA_W-1:0]  m_axis_tdata,

  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // running sum holds up to WINDOW_LEN full-scale magnitudes
  localparam int SUM_W = $clog2(WINDOW_LEN * MAG_MAX + 1);

  // exact division by a constant: floor(n * m / 2^s) with m = ceil(2^s / d),
  // s = n_bits + ceil(log2 d), valid for every n below 2^n_bits
  localparam int      DIV_SHIFT  = SUM_W + $clog2(WINDOW_LEN);
  localparam int      DIV_MUL_W  = SUM_W + 1;
  localparam longint  DivMulL    = ((longint'(1) <<< DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DivMulL);

  localparam int      PCT_SHIFT  = PROD_W + $clog2(PCT_BASE);
  localparam int      PCT_MUL_W  = PROD_W + 1;
  localparam longint  PctMulL    = ((longint'(1) <<< PCT_SHIFT) + PCT_BASE - 1) / PCT_BASE;
  localparam logic [PCT_MUL_W-1:0] PCT_MUL = PCT_MUL_W'(PctMulL);

  // ---------------------------------------------------------------------------
  // configuration registers, always ready
  // ---------------------------------------------------------------------------
  logic [PCT_W-1:0] noise_margin_q;
  logic [LUX_W-1:0] dark_lux_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_margin_q <= NOISE_MARGIN_RST;
      dark_lux_q     <= DARK_LUX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // unknown indexes fall through and are dropped
      unique case (cfg_index_i)
        REG_NOISE_MARGIN: begin
          noise_margin_q <= cfg_data_i[PCT_W-1:0];
        end
        REG_DARK_LUX: begin
          dark_lux_q <= cfg_data_i[LUX_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake chain: a stage loads when it is empty or its successor moves on
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, out_v_q;
  logic rdy1, rdy2, rdy3, out_rdy;
  logic s_xfer;

  assign out_rdy       = !out_v_q || m_axis_tready;
  assign rdy3          = !v3_q || out_rdy;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // input side: rectify, shift the window, update the running sum
  // ---------------------------------------------------------------------------
  logic [ADC_W-1:0] adc;
  logic [LUX_W-1:0] lux;
  logic [MAG_W-1:0] mag;
  logic             lux_low;

  assign adc     = s_axis_tdata[ADC_W-1:0];
  assign lux     = s_axis_tdata[ADC_W +: LUX_W];
  assign mag     = (adc > MIDPOINT) ? (adc - MIDPOINT) : (MIDPOINT - adc);
  assign lux_low = lux < dark_lux_q;

  // index 0 is the oldest entry
  logic [MAG_W-1:0] win_q [WINDOW_LEN];
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_d;

  assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(mag) - (SUM_W+1)'(win_q[0]);
  assign sum_d    = sum_wide[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (s_xfer) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW_LEN-1] <= mag;
      sum_q               <= sum_d;
    end
  end

  // newest RUN_LEN entries after the shift, newest in slot 0
  logic [RUN_LEN-1:0][MAG_W-1:0] run_d;

  always_comb begin
    run_d[0] = mag;
    for (int k = 1; k < RUN_LEN; k++) begin
      run_d[k] = win_q[WINDOW_LEN-k];
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline payload
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]              sum1_q;
  logic [RUN_LEN-1:0][MAG_W-1:0] run1_q, run2_q, run3_q;
  logic                          low1_q, low2_q, low3_q;
  logic [AVG_W-1:0]              avg2_q;
  logic [PROD_W-1:0]             prod3_q;

  // stage 2: window average by reciprocal multiply
  logic [SUM_W+DIV_MUL_W-1:0] avg_full;
  logic [AVG_W-1:0]           avg_d;

  assign avg_full = (SUM_W+DIV_MUL_W)'(sum1_q) * (SUM_W+DIV_MUL_W)'(DIV_MUL);
  assign avg_d    = avg_full[DIV_SHIFT +: AVG_W];

  // stage 3: raise by the margin percentage
  logic [SCALE_W-1:0] scale;
  logic [PROD_W-1:0]  prod_d;

  assign scale  = SCALE_W'(PCT_BASE) + SCALE_W'(noise_margin_q);
  assign prod_d = PROD_W'(avg2_q) * PROD_W'(scale);

  // output stage: divide by 100, saturate, compare the run
  logic [PROD_W+PCT_MUL_W-1:0] thr_full;
  logic [THR_W-1:0]            thr_raw;
  logic [THR_W-1:0]            thr_d;
  logic                        loud_d;

  assign thr_full = (PROD_W+PCT_MUL_W)'(prod3_q) * (PROD_W+PCT_MUL_W)'(PCT_MUL);
  assign thr_raw  = thr_full[PCT_SHIFT +: THR_W];
  assign thr_d    = (thr_raw > THR_MAX) ? THR_MAX : thr_raw;

  always_comb begin
    loud_d = 1'b1;
    for (int k = 0; k < RUN_LEN; k++) begin
      if (!(THR_W'(run3_q[k]) > thr_d)) begin
        loud_d = 1'b0;
      end
    end
  end

  logic             loud_q, light_q;
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q    <= s_axis_tvalid;
      if (rdy2)    v2_q    <= v1_q;
      if (rdy3)    v3_q    <= v2_q;
      if (out_rdy) out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      sum1_q <= sum_d;
      run1_q <= run_d;
      low1_q <= lux_low;
    end
    if (rdy2 && v1_q) begin
      avg2_q <= avg_d;
      run2_q <= run1_q;
      low2_q <= low1_q;
    end
    if (rdy3 && v2_q) begin
      prod3_q <= prod_d;
      run3_q  <= run2_q;
      low3_q  <= low2_q;
    end
    if (out_rdy && v3_q) begin
      loud_q  <= loud_d;
      light_q <= loud_d && low3_q;
      thr_q   <= thr_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(M_TDATA_W-THR_W-2)'(0), thr_q, light_q, loud_q};

`ifndef SYNTHESIS
  // a light request only ever comes with a loud sample
  a_light_needs_loud: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (!light_q || loud_q))
    else $error("light request without loud");

  // threshold stays within its saturation limit
  a_thr_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (thr_q <= THR_MAX))
    else $error("threshold above limit");

  // an accepted sample always lands in the first stage
  a_xfer_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> v1_q)
    else $error("accepted sample lost at first stage");

  // the running sum moves only on an input transfer
  a_sum_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_xfer |=> $stable(sum_q))
    else $error("running sum changed without a transfer");
`endif

endmodule

`default_nettype wire

// ===== dv/loud_sound_light_trigger_unit_tb.sv =====
`timescale 1ns / 100ps

module loud_sound_light_trigger_unit_tb;
  import lslt_pkg::*;

  localparam int WIN_LEN  = 20;
  localparam int LOUD_RUN = 4;
  localparam int SUM_W    = 18;
  localparam int PIPE_LAT = 4;

  // indexes no register answers to
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_DARK_LUX + 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  localparam int HOLD_AFTER  = 400;  // results before the long output stall
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [LUX_W-1:0] lux;
    logic [ADC_W-1:0] adc;
  } mic_sample_t;

  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic             light_req;
    logic             loud;
  } trigger_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // samples waiting to be offered, triggers waiting to come out
  mic_sample_t pending_samples[$];
  trigger_t    expected_triggers[$];

  // predictor state and register copies
  logic [MAG_W-1:0] mic_window [WIN_LEN];
  logic [SUM_W-1:0] mic_sum;
  logic [PCT_W-1:0] margin_pct;
  logic [LUX_W-1:0] lux_limit;

  int  mismatch_cnt = 0;
  int  results_seen = 0;
  logic s_fire = 1'b0;

  // sender burst state
  int burst_left = 0;
  int gap_left   = 0;

  // receiver stall state
  int  rx_mode     = 0;
  int  mode_left   = 0;
  int  hold_left   = 0;
  logic hold_done  = 1'b0;

  loud_sound_light_trigger_unit DUT (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk = ~clk;

  // rectify, shift into the window, threshold and run check for one sample
  task automatic predict_trigger(input logic [ADC_W-1:0] adc, input logic [LUX_W-1:0] lux);
    logic [MAG_W-1:0] mag;
    int               avg;
    int               thr;
    trigger_t         t;
    mag = (adc > MIDPOINT) ? MAG_W'(adc - MIDPOINT) : MAG_W'(MIDPOINT - adc);
    mic_sum = mic_sum - mic_window[0] + mag;
    for (int i = 0; i < WIN_LEN - 1; i++) mic_window[i] = mic_window[i+1];
    mic_window[WIN_LEN-1] = mag;
    avg = int'(mic_sum) / WIN_LEN;
    thr = avg * (PCT_BASE + int'(margin_pct)) / PCT_BASE;
    if (thr > int'(THR_MAX)) thr = int'(THR_MAX);
    t.loud = 1'b1;
    for (int k = 0; k < LOUD_RUN; k++) begin
      if (!(int'(mic_window[WIN_LEN-1-k]) > thr)) t.loud = 1'b0;
    end
    t.light_req = t.loud && (lux < lux_limit);
    t.thr       = THR_W'(thr);
    expected_triggers.push_back(t);
  endtask

  // one write on the register channel, mirrored into the predictor on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      REG_NOISE_MARGIN: margin_pct = data[PCT_W-1:0];
      REG_DARK_LUX:     lux_limit  = data[LUX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every queued sample went in and every trigger came out
  task automatic drain_pipe;
    while (pending_samples.size() != 0 || expected_triggers.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LAT) @(posedge clk);
  endtask

  function automatic void push_sample(input logic [ADC_W-1:0] adc,
                                      input logic [LUX_W-1:0] lux);
    mic_sample_t s;
    s.adc = adc;
    s.lux = lux;
    pending_samples.push_back(s);
  endfunction

  // light reading spread over the whole range, bunched around the limit or at most the limit
  function automatic logic [LUX_W-1:0] pick_lux();
    int v;
    case ($urandom_range(0, 2))
      0:       v = int'($urandom_range(0, 131071));
      1:       v = int'(lux_limit) + int'($urandom_range(0, 4)) - 2;
      default: v = int'($urandom_range(0, lux_limit));
    endcase
    if (v < 0) v = 0;
    if (v > 131071) v = 131071;
    return LUX_W'(v);
  endfunction

  // sample with a given rectified magnitude, on a random side of the midpoint
  function automatic void push_mag(input int mag);
    logic [ADC_W-1:0] adc;
    if (mag >= MAG_MAX) adc = '0;
    else if (mag == 0) adc = MIDPOINT;
    else if ($urandom_range(0, 1)) adc = ADC_W'(int'(MIDPOINT) + mag);
    else adc = ADC_W'(int'(MIDPOINT) - mag);
    push_sample(adc, pick_lux());
  endfunction

  // mostly quiet stretches followed by loud bursts, some shorter than a run,
  // with stretches of raw noise in between
  function automatic void queue_random(input int n);
    int cnt;
    int len;
    int hi;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 2) begin
        len = $urandom_range(1, 5);
        repeat (len) push_sample(ADC_W'($urandom), LUX_W'($urandom));
        cnt += len;
      end else begin
        len = $urandom_range(3, 16);
        hi  = $urandom_range(0, 400);
        repeat (len) push_mag($urandom_range(0, hi));
        cnt += len;
        len = $urandom_range(1, 8);
        repeat (len) push_mag($urandom_range(800, MAG_MAX));
        cnt += len;
      end
    end
  endfunction

  // input transfers feed the predictor, output transfers are checked
  always @(posedge clk) begin : xfer_check
    trigger_t want;
    s_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        void'(pending_samples.pop_front());
        predict_trigger(s_axis_tdata[ADC_W-1:0], s_axis_tdata[ADC_W +: LUX_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_triggers.size() == 0) begin
          $error("trigger result with nothing expected: %h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = expected_triggers.pop_front();
          if (m_axis_tdata[0] !== want.loud) begin
            $error("loud: expected %0d, got %0d", want.loud, m_axis_tdata[0]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[1] !== want.light_req) begin
            $error("light_request: expected %0d, got %0d", want.light_req, m_axis_tdata[1]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[2 +: THR_W] !== want.thr) begin
            $error("level_threshold: expected %0d, got %0d", want.thr,
                   m_axis_tdata[2 +: THR_W]);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // sender: bursts of random length with random gaps, valid held until taken
  always @(negedge clk) begin : sample_driver
    if (s_axis_tvalid && !s_fire) begin
      // offer still open, keep it
    end else if (gap_left > 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (pending_samples.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {1'b0, pending_samples[0]};
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 64);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // receiver: stall modes of random length, plus one long hold-off
  always @(negedge clk) begin : result_sink
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("loud_sound_light_trigger_unit_tb: errors");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < WIN_LEN; i++) mic_window[i] = '0;
    mic_sum    = '0;
    margin_pct = NOISE_MARGIN_RST;
    lux_limit  = DARK_LUX_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // reset settings: rectification corners, lux around the limit, a start-up
    // burst averaged with the cleared window, silence then a full-scale run
    @(posedge clk);
    push_sample(14'd0, 17'd0);
    push_sample(14'd16383, 17'd131071);
    push_sample(MIDPOINT, 17'd49);
    push_sample(MIDPOINT + 14'd1, 17'd50);
    push_sample(MIDPOINT - 14'd1, 17'd51);
    push_sample(14'd0, 17'd0);
    push_sample(14'd0, 17'd49);
    push_sample(14'd0, 17'd50);
    push_sample(14'd0, 17'd131071);
    push_sample(14'd0, 17'd1);
    push_sample(14'd0, 17'd48);
    repeat (8) push_sample(MIDPOINT, 17'd0);
    repeat (4) push_sample(14'd16383, 17'd49);
    push_sample(MIDPOINT, 17'd0);
    drain_pipe();

    // no margin, no light request possible; stray indexes must do nothing
    write_reg(REG_NOISE_MARGIN, 17'h1FF00);
    write_reg(REG_DARK_LUX, 17'd0);
    write_reg(REG_UNUSED_LO, 17'h1FFFF);
    write_reg(REG_UNUSED_HI, 17'h00055);
    @(posedge clk);
    queue_random(150);
    drain_pipe();

    // widest margin, every reading below full-scale lux dark enough
    write_reg(REG_NOISE_MARGIN, 17'h1FFFF);
    write_reg(REG_DARK_LUX, 17'h1FFFF);
    @(posedge clk);
    queue_random(150);
    drain_pipe();

    // random settings for the long run, which also takes the output hold-off
    write_reg(REG_NOISE_MARGIN, CFG_DATA_W'($urandom));
    write_reg(REG_DARK_LUX, CFG_DATA_W'($urandom_range(0, 131071)));
    @(posedge clk);
    queue_random(625);
    drain_pipe();

    if (mismatch_cnt == 0 && expected_triggers.size() == 0) begin
      $display("loud_sound_light_trigger_unit_tb: clean");
    end else begin
      $display("loud_sound_light_trigger_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lslt_pkg.sv
hdl/loud_sound_light_trigger_unit.sv
dv/loud_sound_light_trigger_unit_tb.sv
